[hdl/ncas_pkg.sv]
// Shared types and constants for the nearest-center assignment unit.
// No dependencies; every other file imports this package.
package ncas_pkg;

  localparam int NUM_AXES   = 4;   // x, y, z, w
  localparam int IDX_OUT_W  = 2;   // width of center_index and nearest_center
  localparam int DIST_OUT_W = 34;  // width of squared_distance
  localparam int ACC_W      = 48;  // width of the running sum of squared errors

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Control fields that travel with each item down the cell chain
  typedef struct packed {
    logic                 command;
    logic [IDX_OUT_W-1:0] center_index;
    logic                 last_sample;
  } ncas_ctrl_t;

endpackage

[hdl/ncas_if.sv]
// Valid/ready channel interfaces for the input items and the results.
// Depends on ncas_pkg.
interface ncas_item_if #(parameter int COORD_BITS = 16);
  import ncas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [IDX_OUT_W-1:0]  center_index;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  logic [COORD_BITS-1:0] coord_z;
  logic [COORD_BITS-1:0] coord_w;
  logic                  last_sample;

  modport source (output valid, command, center_index, coord_x, coord_y, coord_z, coord_w,
                  last_sample, input ready);
  modport sink   (input valid, command, center_index, coord_x, coord_y, coord_z, coord_w,
                  last_sample, output ready);
endinterface

interface ncas_result_if;
  import ncas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IDX_OUT_W-1:0]  nearest_center;
  logic [DIST_OUT_W-1:0] squared_distance;
  logic [ACC_W-1:0]      running_sse;
  logic                  set_done;

  modport source (output valid, nearest_center, squared_distance, running_sse, set_done,
                  input ready);
  modport sink   (input valid, nearest_center, squared_distance, running_sse, set_done,
                  output ready);
endinterface

[hdl/ncas_cell.sv]
// One cell of the chain: holds one center, squares the per-axis differences,
// then sums them and keeps the better of the incoming best and its own distance.
// Depends on ncas_pkg.
module ncas_cell #(
  parameter int COORD_BITS = 16,
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = 2
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 up_valid,
  output logic                                                 up_ready,
  input  ncas_pkg::ncas_ctrl_t                                 up_ctrl,
  input  logic [ncas_pkg::NUM_AXES-1:0][COORD_BITS-1:0]        up_sample,
  input  logic [2*COORD_BITS+1:0]                              up_dist,
  input  logic [IDX_W-1:0]                                     up_idx,
  output logic                                                 dn_valid,
  input  logic                                                 dn_ready,
  output ncas_pkg::ncas_ctrl_t                                 dn_ctrl,
  output logic [ncas_pkg::NUM_AXES-1:0][COORD_BITS-1:0]        dn_sample,
  output logic [2*COORD_BITS+1:0]                              dn_dist,
  output logic [IDX_W-1:0]                                     dn_idx
);
  import ncas_pkg::*;

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic [NUM_AXES-1:0][COORD_BITS-1:0] center;

  // square stage
  logic                                a_valid;
  logic                                a_ready;
  ncas_ctrl_t                          a_ctrl;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] a_sample;
  logic [NUM_AXES-1:0][SQ_W-1:0]       a_sq;
  logic [DIST_W-1:0]                   a_best;
  logic [IDX_W-1:0]                    a_idx;

  // compare stage
  logic                                b_valid;
  logic                                b_ready;
  ncas_ctrl_t                          b_ctrl;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] b_sample;
  logic [DIST_W-1:0]                   b_best;
  logic [IDX_W-1:0]                    b_idx;

  logic                                a_take;
  logic                                b_take;
  logic                                center_wr;
  logic [NUM_AXES-1:0][COORD_BITS:0]   diff;
  logic [NUM_AXES-1:0][COORD_BITS:0]   mag;
  logic [NUM_AXES-1:0][SQ_W-1:0]       sq_next;
  logic [DIST_W-1:0]                   d_sum;
  logic                                take_own;

  assign a_ready  = !a_valid || b_ready;
  assign b_ready  = !b_valid || dn_ready;
  assign up_ready = a_ready;
  assign a_take   = up_valid && a_ready;
  assign b_take   = a_valid && b_ready;

  // The index field is two bits wide, so cells from the fifth on never take a load
  assign center_wr = a_take && (up_ctrl.command == CMD_LOAD) && (CELL_INDEX < 4) &&
                     (32'(up_ctrl.center_index) == CELL_INDEX);

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i]    = {up_sample[i][COORD_BITS-1], up_sample[i]} -
                   {center[i][COORD_BITS-1], center[i]};
      mag[i]     = diff[i][COORD_BITS] ? (~diff[i] + 1'b1) : diff[i];
      sq_next[i] = SQ_W'(mag[i][COORD_BITS-1:0]) * SQ_W'(mag[i][COORD_BITS-1:0]);
    end
  end

  assign d_sum = DIST_W'(a_sq[0]) + DIST_W'(a_sq[1]) + DIST_W'(a_sq[2]) + DIST_W'(a_sq[3]);
  // Center 0 always wins over the zero start value; later cells win only when strictly closer
  assign take_own = (CELL_INDEX == 0) || (d_sum < a_best);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      center  <= '0;
    end else begin
      if (a_ready) begin
        a_valid <= up_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (center_wr) begin
        center <= up_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_ctrl   <= up_ctrl;
      a_sample <= up_sample;
      a_sq     <= sq_next;
      a_best   <= up_dist;
      a_idx    <= up_idx;
    end
    if (b_take) begin
      b_ctrl   <= a_ctrl;
      b_sample <= a_sample;
      b_best   <= take_own ? d_sum : a_best;
      b_idx    <= take_own ? IDX_W'(CELL_INDEX) : a_idx;
    end
  end

  assign dn_valid  = b_valid;
  assign dn_ctrl   = b_ctrl;
  assign dn_sample = b_sample;
  assign dn_dist   = b_best;
  assign dn_idx    = b_idx;

endmodule

[hdl/ncas_accum.sv]
// Tail of the chain: saturating sum of squared errors and the output register.
// Depends on ncas_pkg and ncas_result_if.
module ncas_accum #(
  parameter int DIST_W = 34,
  parameter int IDX_W  = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  ncas_pkg::ncas_ctrl_t up_ctrl,
  input  logic [DIST_W-1:0]    up_dist,
  input  logic [IDX_W-1:0]     up_idx,
  ncas_result_if.source        results
);
  import ncas_pkg::*;

  localparam int SUM_W = ((ACC_W > DIST_W) ? ACC_W : DIST_W) + 1;

  logic [ACC_W-1:0]      acc;
  logic                  out_valid;
  logic [IDX_OUT_W-1:0]  out_center;
  logic [DIST_OUT_W-1:0] out_dist;
  logic [ACC_W-1:0]      out_sse;
  logic                  out_done;

  logic                  take;
  logic [SUM_W-1:0]      sum;
  logic [ACC_W-1:0]      sat_sum;

  assign up_ready = !out_valid || results.ready;
  assign take     = up_valid && up_ready;

  assign sum     = SUM_W'(acc) + SUM_W'(up_dist);
  assign sat_sum = (|sum[SUM_W-1:ACC_W]) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (up_ready) begin
        out_valid <= up_valid;
      end
      // Clear after the closing sample; loads leave the sum alone
      if (take && (up_ctrl.command == CMD_CLASSIFY)) begin
        acc <= up_ctrl.last_sample ? '0 : sat_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (up_ctrl.command == CMD_CLASSIFY) begin
        out_center <= up_idx[IDX_OUT_W-1:0];
        out_dist   <= DIST_OUT_W'(up_dist);
        out_sse    <= sat_sum;
        out_done   <= up_ctrl.last_sample;
      end else begin
        out_center <= '0;
        out_dist   <= '0;
        out_sse    <= acc;
        out_done   <= 1'b0;
      end
    end
  end

  assign results.valid            = out_valid;
  assign results.nearest_center   = out_center;
  assign results.squared_distance = out_dist;
  assign results.running_sse      = out_sse;
  assign results.set_done         = out_done;

endmodule

[hdl/nearest_center_assign_sse_unit.sv]
// Top level of the nearest-center assignment unit: chain of center cells and accumulator.
// Depends on ncas_pkg, ncas_if, ncas_cell and ncas_accum.
//
// Load items write one center's four Q8.8 coordinates; classify items are compared with
// every center by squared distance (lowest index wins a tie) and report the nearest
// index, that distance (Q18.16) and a saturating running sum of squared errors, which is
// cleared after an item marked last_sample. Every item gives exactly one result, in
// order. Each center sits in its own cell of a chain; an item passes each cell through
// its square stage and then its sum-and-compare stage, and then the accumulator/output
// register, and one item is taken every cycle unless a stalled result holds the chain.
// A center load takes effect for every item behind it. A stalled result holds the chain
// only once all stages between input and output are full.
module nearest_center_assign_sse_unit #(
  parameter int NUM_CENTERS = 3,
  parameter int COORD_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  ncas_item_if.sink     items,
  ncas_result_if.source results
);
  import ncas_pkg::*;

  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int IDX_W  = ($clog2(NUM_CENTERS) > IDX_OUT_W) ? $clog2(NUM_CENTERS) : IDX_OUT_W;

  logic [NUM_CENTERS:0]                link_valid;
  logic [NUM_CENTERS:0]                link_ready;
  ncas_ctrl_t                          link_ctrl   [NUM_CENTERS+1];
  logic [NUM_AXES-1:0][COORD_BITS-1:0] link_sample [NUM_CENTERS+1];
  logic [DIST_W-1:0]                   link_dist   [NUM_CENTERS+1];
  logic [IDX_W-1:0]                    link_idx    [NUM_CENTERS+1];

  assign link_valid[0]          = items.valid;
  assign items.ready            = link_ready[0];
  assign link_ctrl[0].command      = items.command;
  assign link_ctrl[0].center_index = items.center_index;
  assign link_ctrl[0].last_sample  = items.last_sample;
  assign link_sample[0][0]      = items.coord_x;
  assign link_sample[0][1]      = items.coord_y;
  assign link_sample[0][2]      = items.coord_z;
  assign link_sample[0][3]      = items.coord_w;
  assign link_dist[0]           = '0;
  assign link_idx[0]            = '0;

  for (genvar k = 0; k < NUM_CENTERS; k++) begin : g_cell
    ncas_cell #(
      .COORD_BITS (COORD_BITS),
      .CELL_INDEX (k),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (link_valid[k]),
      .up_ready  (link_ready[k]),
      .up_ctrl   (link_ctrl[k]),
      .up_sample (link_sample[k]),
      .up_dist   (link_dist[k]),
      .up_idx    (link_idx[k]),
      .dn_valid  (link_valid[k+1]),
      .dn_ready  (link_ready[k+1]),
      .dn_ctrl   (link_ctrl[k+1]),
      .dn_sample (link_sample[k+1]),
      .dn_dist   (link_dist[k+1]),
      .dn_idx    (link_idx[k+1])
    );
  end

  ncas_accum #(
    .DIST_W (DIST_W),
    .IDX_W  (IDX_W)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (link_valid[NUM_CENTERS]),
    .up_ready (link_ready[NUM_CENTERS]),
    .up_ctrl  (link_ctrl[NUM_CENTERS]),
    .up_dist  (link_dist[NUM_CENTERS]),
    .up_idx   (link_idx[NUM_CENTERS]),
    .results  (results)
  );

  // Only existing centers can be reported
  a_center_in_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (32'(results.nearest_center) < NUM_CENTERS))
    else $error("nearest_center out of range");

  // The input stalls only when a result is waiting and not taken
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (results.valid && !results.ready))
    else $error("input stalled without output backpressure");

  // The running sum always covers the reported distance
  a_sse_covers_dist: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.running_sse >= ACC_W'(results.squared_distance)))
    else $error("running_sse below squared_distance");

endmodule
